/* sv/psa_pkg.sv */
// ----------------------------------------------------------------------------
// psa_pkg
// Shared constants, codes and state type for the pooled slot allocator.
// ----------------------------------------------------------------------------
package psa_pkg;

   localparam int MaxPools      = 8;
   localparam int MaxSlots      = 64;
   localparam int PendDepth     = 64;
   localparam int PoolW         = 3;
   localparam int SlotW         = 6;
   localparam int CntW          = 7;
   localparam int SerW          = 48;
   localparam int RecW          = 6;
   localparam int RefW          = 2;
   localparam int FreeAddrW     = PoolW + SlotW;
   localparam int FifoAddrW     = 1 + RecW;
   localparam int FifoWordW     = RecW + SerW;
   localparam int RecWordW      = PoolW + SlotW + RefW;

   localparam logic [1:0] KindAlloc    = 2'd0;
   localparam logic [1:0] KindRelease  = 2'd1;
   localparam logic [1:0] KindComplete = 2'd2;

   localparam logic [1:0] StatOk      = 2'd0;
   localparam logic [1:0] StatNoSlot  = 2'd1;
   localparam logic [1:0] StatPendFull = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ALLOC,
      S_ALLOC_POP,
      S_ALLOC_RD,
      S_REL,
      S_REL2,
      S_CMP_HEAD,
      S_CMP_CHK,
      S_CMP_REC,
      S_DONE
   } state_type;

endpackage

/* sv/psa_ram.sv */
// ----------------------------------------------------------------------------
// psa_ram
// Simple dual-port synchronous RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module psa_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/pooled_slot_allocator_deferred_free_core.sv */
// ----------------------------------------------------------------------------
// pooled_slot_allocator_deferred_free_core
// Two-level slot allocator with deferred release through per-queue FIFOs.
// ----------------------------------------------------------------------------
// One item is worked at a time and gives one result item. An allocate passes
// through pool open, pop, free-stack RAM read and output load; a release
// through record allocate, then second queue push and record write, then
// output load, skipping the middle step when it frees at once or fails. A
// completion reads its FIFO head and loads the output when the FIFO is empty
// or the head entry is not yet done; each FIFO entry retired needs a FIFO RAM
// read, a record RAM read and a record write-back in turn. A new item is taken
// while the last result still waits on the output. Free stacks, queue FIFOs
// and pending records sit in three RAMs; no clearing pass is needed after
// reset, since a newly opened pool's stack reads as slot i at depth i until first overwritten.
module pooled_slot_allocator_deferred_free_core (
   input  logic         clock,
   input  logic         reset,
   // config
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [6:0]   csr_data,      // sets_per_pool
   // request
   input  logic         req_tvalid,
   output logic         req_tready,
   // pool_index[2:0], set_index[8:3], used_graphics[9], used_compute[10],
   // graphics_serial[58:11], compute_serial[106:59], queue_id[107],
   // completed_serial[155:108], zero[159:156]
   input  logic [159:0] req_tdata,
   input  logic [1:0]   req_tuser,     // kind
   // response
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_pool[2:0], out_slot[8:3], notify_graphics[9], notify_compute[10],
   // freed_count[17:11], zero[23:18]
   output logic [23:0]  rsp_tdata,
   output logic [1:0]   rsp_tuser      // status
);

   import psa_pkg::*;

   state_type state_ff, state_in;

   logic [CntW-1:0]  sets_ff, sets_in;
   logic [PoolW-1:0] pool_ff, pool_in;
   logic [SlotW-1:0] slot_ff, slot_in;
   logic             ug_ff, ug_in, uc_ff, uc_in, q_ff, q_in;
   logic [SerW-1:0]  ser0_ff, ser0_in, ser1_ff, ser1_in, done_ff, done_in;

   logic [CntW-1:0]  fcnt_ff [MaxPools];
   logic [CntW-1:0]  fcnt_in [MaxPools];
   logic [CntW-1:0]  low_ff [MaxPools];
   logic [CntW-1:0]  low_in [MaxPools];
   logic [PoolW-1:0] stk_ff [MaxPools];
   logic [PoolW-1:0] stk_in [MaxPools];
   logic [PoolW:0]   open_ff, open_in, avail_ff, avail_in;

   logic [PendDepth-1:0] rvalid_ff, rvalid_in;
   logic [RecW-1:0]  head_ff [2];
   logic [RecW-1:0]  head_in [2];
   logic [RecW:0]    qcnt_ff [2];
   logic [RecW:0]    qcnt_in [2];
   logic [SerW-1:0]  last_ff [2];
   logic [SerW-1:0]  last_in [2];

   logic [RecW-1:0]  ridx_ff, ridx_in;
   logic [RefW-1:0]  refs_ff, refs_in;
   logic             msel_ff, msel_in;

   logic [1:0]       rs_stat_ff, rs_stat_in;
   logic [PoolW-1:0] rs_pool_ff, rs_pool_in;
   logic [SlotW-1:0] rs_slot_ff, rs_slot_in;
   logic             rs_ng_ff, rs_ng_in, rs_nc_ff, rs_nc_in;
   logic [CntW-1:0]  rs_freed_ff, rs_freed_in;

   logic             o_valid_ff, o_valid_in;
   logic [1:0]       o_stat_ff, o_stat_in;
   logic [23:0]      o_data_ff, o_data_in;

   // ram ports
   logic                 fs_we;
   logic [FreeAddrW-1:0] fs_waddr, fs_raddr;
   logic [SlotW-1:0]     fs_wdata, fs_rdata;
   logic                 ff_we;
   logic [FifoAddrW-1:0] ff_waddr, ff_raddr;
   logic [FifoWordW-1:0] ff_wdata, ff_rdata;
   logic                 rc_we;
   logic [RecW-1:0]      rc_waddr, rc_raddr;
   logic [RecWordW-1:0]  rc_wdata, rc_rdata;

   // shared condition wires
   logic             req_fire, out_load;
   logic             rel_bad, rel_direct, rec_found;
   logic [RecW-1:0]  rec_free;
   logic [CntW-1:0]  n_open;
   logic             head_ok;

   psa_ram #(.DEPTH(MaxPools * MaxSlots), .WIDTH(SlotW)) u_free_stack (
      .clock(clock), .wr_en(fs_we), .wr_addr(fs_waddr), .wr_data(fs_wdata),
      .rd_addr(fs_raddr), .rd_data(fs_rdata)
   );

   psa_ram #(.DEPTH(2 * PendDepth), .WIDTH(FifoWordW)) u_queue_fifo (
      .clock(clock), .wr_en(ff_we), .wr_addr(ff_waddr), .wr_data(ff_wdata),
      .rd_addr(ff_raddr), .rd_data(ff_rdata)
   );

   psa_ram #(.DEPTH(PendDepth), .WIDTH(RecWordW)) u_pend_rec (
      .clock(clock), .wr_en(rc_we), .wr_addr(rc_waddr), .wr_data(rc_wdata),
      .rd_addr(rc_raddr), .rd_data(rc_rdata)
   );

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_load   = (state_ff == S_DONE) && (!o_valid_ff || rsp_tready);
   assign rsp_tvalid = o_valid_ff;
   assign rsp_tdata  = o_data_ff;
   assign rsp_tuser  = o_stat_ff;

   // first free pending record
   always_comb begin
      rec_free  = '0;
      rec_found = 1'b0;
      for (int i = PendDepth - 1; i >= 0; i--) begin
         if (!rvalid_ff[i]) begin
            rec_free  = RecW'(i);
            rec_found = 1'b1;
         end
      end
   end

   // release and completion conditions
   assign rel_bad    = ({1'b0, pool_ff} >= open_ff);
   assign rel_direct = !ug_ff && !uc_ff;
   assign head_ok    = (ff_rdata[SerW-1:0] <= done_ff);
   assign n_open     = (sets_ff == '0) ? CntW'(1) :
                       (sets_ff > CntW'(MaxSlots)) ? CntW'(MaxSlots) : sets_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_tuser)
                  KindAlloc:    state_in = S_ALLOC;
                  KindRelease:  state_in = S_REL;
                  KindComplete: state_in = S_CMP_HEAD;
                  default:      state_in = S_DONE;
               endcase
            end
         end
         S_ALLOC:     state_in = S_ALLOC_POP;
         S_ALLOC_POP: state_in = S_ALLOC_RD;
         S_ALLOC_RD:  state_in = S_DONE;
         S_REL: begin
            if (rel_bad || rel_direct || !rec_found) begin
               state_in = S_DONE;
            end else begin
               state_in = S_REL2;
            end
         end
         S_REL2: state_in = S_DONE;
         S_CMP_HEAD: begin
            state_in = (qcnt_ff[q_ff] == '0) ? S_DONE : S_CMP_CHK;
         end
         S_CMP_CHK: state_in = head_ok ? S_CMP_REC : S_DONE;
         S_CMP_REC: state_in = S_CMP_HEAD;
         S_DONE: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      logic [PoolW-1:0] p;
      logic [CntW-1:0]  c;
      logic             push_req, push_ok;
      logic [PoolW-1:0] push_pool;
      logic [SlotW-1:0] push_slot;
      logic [RefW-1:0]  r;

      sets_in = csr_valid ? csr_data : sets_ff;
      pool_in = pool_ff; slot_in = slot_ff;
      ug_in = ug_ff; uc_in = uc_ff; q_in = q_ff;
      ser0_in = ser0_ff; ser1_in = ser1_ff; done_in = done_ff;
      fcnt_in = fcnt_ff; low_in = low_ff; stk_in = stk_ff;
      open_in = open_ff; avail_in = avail_ff; rvalid_in = rvalid_ff;
      head_in = head_ff; qcnt_in = qcnt_ff; last_in = last_ff;
      ridx_in = ridx_ff; refs_in = refs_ff; msel_in = msel_ff;
      rs_stat_in = rs_stat_ff; rs_pool_in = rs_pool_ff; rs_slot_in = rs_slot_ff;
      rs_ng_in = rs_ng_ff; rs_nc_in = rs_nc_ff; rs_freed_in = rs_freed_ff;
      fs_we = 1'b0; fs_waddr = '0; fs_wdata = '0; fs_raddr = '0;
      ff_we = 1'b0; ff_waddr = '0; ff_wdata = '0; ff_raddr = '0;
      rc_we = 1'b0; rc_waddr = '0; rc_wdata = '0; rc_raddr = '0;
      push_req = 1'b0; push_pool = pool_ff; push_slot = slot_ff;
      p = '0; c = '0; r = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               pool_in = req_tdata[2:0];
               slot_in = req_tdata[8:3];
               ug_in   = req_tdata[9];
               uc_in   = req_tdata[10];
               ser0_in = req_tdata[58:11];
               ser1_in = req_tdata[106:59];
               q_in    = req_tdata[107];
               done_in = req_tdata[155:108];
               rs_stat_in = StatOk; rs_pool_in = '0; rs_slot_in = '0;
               rs_ng_in = 1'b0; rs_nc_in = 1'b0; rs_freed_in = '0;
               msel_in = 1'b0;
            end
         end
         // open a new pool when none has a free slot
         S_ALLOC: begin
            if (avail_ff == '0 && open_ff < (PoolW+1)'(MaxPools)) begin
               p = open_ff[PoolW-1:0];
               fcnt_in[p] = n_open;
               low_in[p]  = n_open;
               open_in    = open_ff + 1'b1;
               stk_in[0]  = p;
               avail_in   = (PoolW+1)'(1);
            end
         end
         // pop a slot from the top listed pool
         S_ALLOC_POP: begin
            if (avail_ff == '0) begin
               rs_stat_in = StatNoSlot;
            end else begin
               p = stk_ff[avail_ff[PoolW-1:0] - 1'b1];
               if (fcnt_ff[p] == '0) begin
                  rs_stat_in = StatNoSlot;
               end else begin
                  c = fcnt_ff[p] - 1'b1;
                  fcnt_in[p] = c;
                  rs_pool_in = p;
                  rs_slot_in = c[SlotW-1:0];
                  msel_in    = (c >= low_ff[p]);
                  if (c < low_ff[p]) begin
                     low_in[p] = c;
                  end
                  fs_raddr = {p, c[SlotW-1:0]};
                  if (c == '0) begin
                     avail_in = avail_ff - 1'b1;
                  end
               end
            end
         end
         S_ALLOC_RD: begin
            if (msel_ff) begin
               rs_slot_in = fs_rdata;
            end
         end
         // release: free now or take a record and queue on graphics; a bad pool or a full record store fails
         S_REL: begin
            if (rel_bad) begin
               rs_stat_in = StatNoSlot;
            end else if (rel_direct) begin
               push_req = 1'b1;
            end else if (!rec_found) begin
               rs_stat_in = StatPendFull;
            end else begin
               rvalid_in[rec_free] = 1'b1;
               ridx_in = rec_free;
               refs_in = '0;
               if (ug_ff && qcnt_ff[0] < (RecW+1)'(PendDepth)) begin
                  ff_we    = 1'b1;
                  ff_waddr = {1'b0, RecW'(head_ff[0] + qcnt_ff[0][RecW-1:0])};
                  ff_wdata = {rec_free, ser0_ff};
                  qcnt_in[0] = qcnt_ff[0] + 1'b1;
                  refs_in = RefW'(1);
                  if (last_ff[0] != ser0_ff) begin
                     last_in[0] = ser0_ff;
                     rs_ng_in = 1'b1;
                  end
               end
            end
         end
         // queue on compute and write the record
         S_REL2: begin
            r = refs_ff;
            if (uc_ff && qcnt_ff[1] < (RecW+1)'(PendDepth)) begin
               ff_we    = 1'b1;
               ff_waddr = {1'b1, RecW'(head_ff[1] + qcnt_ff[1][RecW-1:0])};
               ff_wdata = {ridx_ff, ser1_ff};
               qcnt_in[1] = qcnt_ff[1] + 1'b1;
               r = refs_ff + 1'b1;
               if (last_ff[1] != ser1_ff) begin
                  last_in[1] = ser1_ff;
                  rs_nc_in = 1'b1;
               end
            end
            rc_we    = 1'b1;
            rc_waddr = ridx_ff;
            rc_wdata = {pool_ff, slot_ff, r};
         end
         S_CMP_HEAD: begin
            ff_raddr = {q_ff, head_ff[q_ff]};
         end
         // retire the head entry if its serial is done
         S_CMP_CHK: begin
            if (head_ok) begin
               head_in[q_ff] = head_ff[q_ff] + 1'b1;
               qcnt_in[q_ff] = qcnt_ff[q_ff] - 1'b1;
               rc_raddr = ff_rdata[FifoWordW-1:SerW];
               ridx_in  = ff_rdata[FifoWordW-1:SerW];
            end
         end
         // drop one reference, free the slot at zero
         S_CMP_REC: begin
            r = rc_rdata[RefW-1:0];
            if (rvalid_ff[ridx_ff] && r != '0) begin
               rc_we    = 1'b1;
               rc_waddr = ridx_ff;
               rc_wdata = {rc_rdata[RecWordW-1:RefW], RefW'(r - 1'b1)};
               if (r == RefW'(1)) begin
                  rvalid_in[ridx_ff] = 1'b0;
                  push_req  = 1'b1;
                  push_pool = rc_rdata[RecWordW-1:RefW+SlotW];
                  push_slot = rc_rdata[RefW+SlotW-1:RefW];
               end
            end
         end
         S_DONE: ;
         default: ;
      endcase

      // return a slot to its pool's free stack
      push_ok = push_req && ({1'b0, push_pool} < open_ff)
                && (fcnt_ff[push_pool] < CntW'(MaxSlots));
      if (push_ok) begin
         if (fcnt_ff[push_pool] == '0 && avail_ff < (PoolW+1)'(MaxPools)) begin
            stk_in[avail_ff[PoolW-1:0]] = push_pool;
            avail_in = avail_ff + 1'b1;
         end
         fs_we    = 1'b1;
         fs_waddr = {push_pool, fcnt_ff[push_pool][SlotW-1:0]};
         fs_wdata = push_slot;
         fcnt_in[push_pool] = fcnt_ff[push_pool] + 1'b1;
         if (rs_freed_ff != '1) begin
            rs_freed_in = rs_freed_ff + 1'b1;
         end
      end
   end

   // output register
   always_comb begin
      o_valid_in = o_valid_ff && !rsp_tready;
      o_stat_in  = o_stat_ff;
      o_data_in  = o_data_ff;
      if (out_load) begin
         o_valid_in = 1'b1;
         o_stat_in  = rs_stat_ff;
         o_data_in  = {6'd0, rs_freed_ff, rs_nc_ff, rs_ng_ff, rs_slot_ff, rs_pool_ff};
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         sets_ff    <= CntW'(MaxSlots);
         open_ff    <= '0;
         avail_ff   <= '0;
         rvalid_ff  <= '0;
         o_valid_ff <= 1'b0;
         for (int i = 0; i < MaxPools; i++) begin
            fcnt_ff[i] <= '0;
         end
         for (int i = 0; i < 2; i++) begin
            head_ff[i] <= '0;
            qcnt_ff[i] <= '0;
            last_ff[i] <= '0;
         end
      end else begin
         state_ff   <= state_in;
         sets_ff    <= sets_in;
         open_ff    <= open_in;
         avail_ff   <= avail_in;
         rvalid_ff  <= rvalid_in;
         o_valid_ff <= o_valid_in;
         fcnt_ff    <= fcnt_in;
         head_ff    <= head_in;
         qcnt_ff    <= qcnt_in;
         last_ff    <= last_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pool_ff <= pool_in; slot_ff <= slot_in;
      ug_ff <= ug_in; uc_ff <= uc_in; q_ff <= q_in;
      ser0_ff <= ser0_in; ser1_ff <= ser1_in; done_ff <= done_in;
      low_ff <= low_in; stk_ff <= stk_in;
      ridx_ff <= ridx_in; refs_ff <= refs_in; msel_ff <= msel_in;
      rs_stat_ff <= rs_stat_in; rs_pool_ff <= rs_pool_in; rs_slot_ff <= rs_slot_in;
      rs_ng_ff <= rs_ng_in; rs_nc_ff <= rs_nc_in; rs_freed_ff <= rs_freed_in;
      o_stat_ff <= o_stat_in; o_data_ff <= o_data_in;
   end

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the pooled slot allocator: a queue-fed driver, a
// response monitor and a behavioral predictor of pools, free stacks, pending
// records and per-queue release FIFOs, compared field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
   import psa_pkg::*;

   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  pool;
      logic [5:0]  slot;
      logic        use_g;
      logic        use_c;
      logic [47:0] ser_g;
      logic [47:0] ser_c;
      logic        qid;
      logic [47:0] done;
   } alloc_req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [2:0] pool;
      logic [5:0] slot;
      logic       ng;
      logic       nc;
      logic [6:0] freed;
   } alloc_rsp_type;

   logic         clock = 0;
   logic         reset = 1;
   logic         csr_valid = 0;
   logic         csr_ready;
   logic [6:0]   csr_data = 0;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [159:0] req_tdata = 0;
   logic [1:0]   req_tuser = 0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [23:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;

   pooled_slot_allocator_deferred_free_core dut (.*);

   // predictor state
   int          spp;
   logic [5:0]  free_stk [MaxPools][MaxSlots];
   int          free_cnt [MaxPools];
   int          open_cnt;
   int          avail_stk [MaxPools];
   int          avail_cnt;
   bit          rec_valid [PendDepth];
   int          rec_pool [PendDepth];
   int          rec_slot [PendDepth];
   int          rec_refs [PendDepth];
   logic [47:0] fifo_ser [2][PendDepth];
   int          fifo_rec [2][PendDepth];
   int          fifo_head [2];
   int          fifo_cnt [2];
   logic [47:0] last_ser [2];

   alloc_req_type  pending_items[$];
   alloc_rsp_type  expected_rsps[$];
   int          errors = 0;
   int          n_sent = 0;
   int          n_checked = 0;
   bit          stim_done = 0;

   logic [6:0] spp_set [4] = '{7'd1, 7'd64, 7'd3, 7'd17};

   initial forever #10 clock = ~clock;

   function automatic bit free_slot(int p, logic [5:0] s);
      if (p >= open_cnt || free_cnt[p] >= MaxSlots) return 0;
      if (free_cnt[p] == 0 && avail_cnt < MaxPools) begin
         avail_stk[avail_cnt] = p;
         avail_cnt++;
      end
      free_stk[p][free_cnt[p]] = s;
      free_cnt[p]++;
      return 1;
   endfunction

   function automatic alloc_rsp_type predict_allocator(alloc_req_type it);
      alloc_rsp_type r;
      int n, p, rr, pos;
      bit used;
      r = '0;
      if (it.kind == KindAlloc) begin
         if (avail_cnt == 0 && open_cnt < MaxPools) begin
            n = spp < 1 ? 1 : (spp > MaxSlots ? MaxSlots : spp);
            for (int i = 0; i < n; i++) free_stk[open_cnt][i] = 6'(i);
            free_cnt[open_cnt] = n;
            avail_stk[avail_cnt] = open_cnt;
            avail_cnt++;
            open_cnt++;
         end
         if (avail_cnt == 0) r.status = StatNoSlot;
         else begin
            p = avail_stk[avail_cnt - 1];
            if (free_cnt[p] == 0) r.status = StatNoSlot;
            else begin
               free_cnt[p]--;
               r.slot = free_stk[p][free_cnt[p]];
               r.pool = 3'(p);
               if (free_cnt[p] == 0) avail_cnt--;
            end
         end
      end else if (it.kind == KindRelease) begin
         if (int'(it.pool) >= open_cnt) r.status = StatNoSlot;
         else if (!it.use_g && !it.use_c) r.freed = 7'(free_slot(int'(it.pool), it.slot));
         else begin
            for (rr = 0; rr < PendDepth; rr++) if (!rec_valid[rr]) break;
            if (rr == PendDepth) r.status = StatPendFull;
            else begin
               rec_valid[rr] = 1;
               rec_pool[rr] = int'(it.pool);
               rec_slot[rr] = int'(it.slot);
               rec_refs[rr] = 0;
               for (int q = 0; q < 2; q++) begin
                  used = q == 0 ? it.use_g : it.use_c;
                  if (used && fifo_cnt[q] < PendDepth) begin
                     pos = (fifo_head[q] + fifo_cnt[q]) % PendDepth;
                     fifo_ser[q][pos] = q == 0 ? it.ser_g : it.ser_c;
                     fifo_rec[q][pos] = rr;
                     fifo_cnt[q]++;
                     rec_refs[rr]++;
                     if (last_ser[q] != fifo_ser[q][pos]) begin
                        last_ser[q] = fifo_ser[q][pos];
                        if (q == 0) r.ng = 1; else r.nc = 1;
                     end
                  end
               end
            end
         end
      end else if (it.kind == KindComplete) begin
         while (fifo_cnt[it.qid] > 0 && fifo_ser[it.qid][fifo_head[it.qid]] <= it.done) begin
            rr = fifo_rec[it.qid][fifo_head[it.qid]];
            fifo_head[it.qid] = (fifo_head[it.qid] + 1) % PendDepth;
            fifo_cnt[it.qid]--;
            if (!rec_valid[rr] || rec_refs[rr] == 0) continue;
            rec_refs[rr]--;
            if (rec_refs[rr] == 0) begin
               rec_valid[rr] = 0;
               if (free_slot(rec_pool[rr], 6'(rec_slot[rr])) && r.freed < 127) r.freed++;
            end
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch on %s: got %0d, expected %0d", what, got, want);
      errors++;
   endtask

   // append one item to the stimulus queue
   function automatic void add_item(alloc_req_type it);
      pending_items.insert(pending_items.size(), it);
   endfunction

   // gap length: mostly short, sometimes long
   function automatic int pick_gap();
      int c;
      c = $urandom_range(0, 99);
      if (c < 45) return 0;
      if (c < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // driver
   int drv_gap = 0;
   always @(posedge clock) begin
      alloc_req_type it;
      if (reset) begin
         req_tvalid <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) n_sent++;
         if (drv_gap > 0) begin
            drv_gap <= drv_gap - 1;
            req_tvalid <= 0;
         end else if (pending_items.size() > 0) begin
            it = pending_items.pop_front();
            expected_rsps.insert(expected_rsps.size(), predict_allocator(it));
            req_tuser <= it.kind;
            req_tdata <= {4'b0, it.done, it.qid, it.ser_c, it.ser_g,
                          it.use_c, it.use_g, it.slot, it.pool};
            req_tvalid <= 1;
            drv_gap <= pick_gap();
         end else begin
            req_tvalid <= 0;
         end
      end
   end

   // monitor
   int mon_gap = 0;
   always @(posedge clock) begin
      alloc_rsp_type want;
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            n_checked++;
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected item", 1, 0);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_tuser != want.status)
                  report_mismatch("status", int'(rsp_tuser), int'(want.status));
               if (rsp_tdata[2:0] != want.pool)
                  report_mismatch("pool", int'(rsp_tdata[2:0]), int'(want.pool));
               if (rsp_tdata[8:3] != want.slot)
                  report_mismatch("slot", int'(rsp_tdata[8:3]), int'(want.slot));
               if (rsp_tdata[9] != want.ng)
                  report_mismatch("notify_g", int'(rsp_tdata[9]), int'(want.ng));
               if (rsp_tdata[10] != want.nc)
                  report_mismatch("notify_c", int'(rsp_tdata[10]), int'(want.nc));
               if (rsp_tdata[17:11] != want.freed)
                  report_mismatch("freed", int'(rsp_tdata[17:11]), int'(want.freed));
            end
         end
         if (mon_gap > 0) begin
            mon_gap <= mon_gap - 1;
            rsp_tready <= 0;
         end else begin
            rsp_tready <= 1;
            mon_gap <= pick_gap();
         end
      end
   end

   function automatic alloc_req_type mk(logic [1:0] k);
      alloc_req_type it;
      logic [191:0]  rnd;
      rnd = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      it = rnd[$bits(alloc_req_type)-1:0];
      it.kind = k;
      return it;
   endfunction

   function automatic alloc_req_type mk_rel(int p, int s, bit g, bit c, longint sg, longint sc);
      alloc_req_type it;
      it = mk(KindRelease);
      it.pool = 3'(p); it.slot = 6'(s); it.use_g = g; it.use_c = c;
      it.ser_g = 48'(sg); it.ser_c = 48'(sc);
      return it;
   endfunction

   function automatic alloc_req_type mk_cmp(bit q, longint d);
      alloc_req_type it;
      it = mk(KindComplete);
      it.qid = q; it.done = 48'(d);
      return it;
   endfunction

   task automatic wait_idle();
      wait (pending_items.size() == 0 && expected_rsps.size() == 0 && !req_tvalid);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_spp(logic [6:0] v);
      @(posedge clock);
      csr_valid <= 1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      spp = int'(v);
   endtask

   // random traffic phase: mostly sane allocate/release/complete mixes
   task automatic random_phase(int n);
      longint ser [2];
      alloc_req_type it;
      int c;
      ser[0] = $urandom_range(1, 50);
      ser[1] = $urandom_range(1, 50);
      for (int i = 0; i < n; i++) begin
         c = $urandom_range(0, 99);
         if (c < 35) it = mk(KindAlloc);
         else if (c < 75) begin
            if ($urandom_range(0, 3) == 0) begin
               ser[0] += $urandom_range(0, 1);
               ser[1] += $urandom_range(0, 1);
            end
            it = mk_rel($urandom_range(0, 7), $urandom_range(0, 63),
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                        $urandom_range(0, 9) == 0 ? {$urandom, $urandom} : ser[0] - $urandom_range(0, 2),
                        $urandom_range(0, 9) == 0 ? {$urandom, $urandom} : ser[1] - $urandom_range(0, 2));
            it.pool = 3'($urandom_range(0, 3) == 0 ? $urandom_range(0, 7) : $urandom_range(0, 2));
         end else if (c < 97) begin
            it = mk_cmp(1'($urandom_range(0, 1)), 0);
            it.done = 48'($urandom_range(0, 9) == 0 ? {$urandom, $urandom}
                          : ser[it.qid] - $urandom_range(0, 3));
         end else it = mk(2'd3);
         add_item(it);
      end
   endtask

   initial begin
      spp = 64;
      open_cnt = 0; avail_cnt = 0;
      foreach (free_cnt[i]) free_cnt[i] = 0;
      foreach (rec_valid[i]) rec_valid[i] = 0;
      fifo_head = '{0, 0}; fifo_cnt = '{0, 0};
      last_ser = '{48'd0, 48'd0};
      repeat (3) @(posedge clock);
      reset <= 0;

      // directed: extremes, every kind, special cases
      add_item(mk_rel(0, 5, 0, 0, 0, 0));          // pool never opened
      add_item(mk(KindAlloc));
      add_item(mk(KindAlloc));
      add_item(mk_rel(0, 63, 0, 0, 0, 0));         // immediate free
      add_item(mk_rel(0, 62, 1, 0, '1, 0));        // max serial
      add_item(mk_rel(0, 61, 1, 1, 5, 7));
      add_item(mk_rel(0, 60, 1, 1, 5, 7));         // same serial, no notify
      add_item(mk_rel(0, 59, 1, 0, 3, 0));         // out of order
      add_item(mk_cmp(0, 4));                      // head blocks
      add_item(mk_cmp(1, 7));
      add_item(mk_cmp(0, '1));
      add_item(mk(2'd3));
      add_item(mk_cmp(1, 0));
      wait_idle();

      // tiny pools: sets_per_pool 0 acts as 1 for pools opened from here on
      write_spp(0);
      random_phase(0);
      for (int i = 0; i < 10; i++) add_item(mk(KindAlloc));
      for (int i = 0; i < 8; i++) add_item(mk_rel(i, 0, 0, 0, 0, 0));
      wait_idle();
      random_phase(300);
      wait_idle();

      // fill the pending store past its depth
      write_spp(127);
      for (int i = 0; i < 70; i++) add_item(mk_rel(0, i % 64, 1, 0, 9, 0));
      add_item(mk_cmp(0, 9));                      // many frees at once
      wait_idle();
      random_phase(400);
      wait_idle();

      foreach (spp_set[i]) begin
         write_spp(spp_set[i]);
         random_phase(300);
         wait_idle();
      end
      stim_done = 1;
   end

   initial begin
      wait (stim_done);
      $display("checked %0d result items over %0d requests, pool sizes 0 to 127", n_checked, n_sent);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #50ms;
      $display("timeout");
      $display("Verification failed");
      $finish;
   end

endmodule
